// ===== hw/rtl/quaternion_point_frame_transform_core_assert.svh =====
// assertion macros for the quaternion point frame transform core
`ifndef QUATERNION_POINT_FRAME_TRANSFORM_CORE_ASSERT_SVH
`define QUATERNION_POINT_FRAME_TRANSFORM_CORE_ASSERT_SVH

`ifndef SYNTH
`define QPFT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define QPFT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define QPFT_ASSERT_IMP(label, ante, cons, msg)
`define QPFT_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

// ===== hw/rtl/qpft_pkg.sv =====
// types, constants and helpers of the quaternion point frame transform
package qpft_pkg;

  typedef logic signed [15:0] quat_t;
  typedef logic signed [31:0] coord_t;
  typedef logic signed [29:0] qprod_t;
  typedef logic signed [31:0] mat_t;
  typedef logic signed [62:0] mprod_t;
  typedef logic signed [63:0] acc_t;
  typedef logic signed [36:0] rsum_t;

  localparam int unsigned FracShift = 28;

  localparam quat_t  QMAG       = 16'sd16384;
  localparam quat_t  QMAG_NEG   = -16'sd16384;
  localparam coord_t COORD_MAX  = 32'sh7fffffff;
  localparam coord_t COORD_MIN  = 32'sh80000000;
  localparam acc_t   ROUND_HALF = 64'sd134217728;

  localparam int unsigned PaddrW = 5;

  typedef enum logic [2:0] {
    REG_ROT_W   = 3'd0,
    REG_ROT_X   = 3'd1,
    REG_ROT_Y   = 3'd2,
    REG_ROT_Z   = 3'd3,
    REG_SHIFT_X = 3'd4,
    REG_SHIFT_Y = 3'd5,
    REG_SHIFT_Z = 3'd6
  } reg_idx_e;

  function automatic quat_t clamp_q(input quat_t v);
    quat_t r;
    r = v;
    if (v > QMAG) begin
      r = QMAG;
    end else if (v < QMAG_NEG) begin
      r = QMAG_NEG;
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/qpft_if.sv =====
// point request and result channels
interface qpft_in_if
  import qpft_pkg::*;
();
  logic   valid;
  logic   ready;
  coord_t point_x;
  coord_t point_y;
  coord_t point_z;
  logic   last_point;

  modport source (output valid, point_x, point_y, point_z, last_point, input ready);
  modport sink   (input valid, point_x, point_y, point_z, last_point, output ready);
endinterface

interface qpft_out_if
  import qpft_pkg::*;
();
  logic   valid;
  logic   ready;
  coord_t out_x;
  coord_t out_y;
  coord_t out_z;
  logic   last_result;
  logic   saturated;

  modport source (output valid, out_x, out_y, out_z, last_result, saturated, input ready);
  modport sink   (input valid, out_x, out_y, out_z, last_result, saturated, output ready);
endinterface

// ===== hw/rtl/quaternion_point_frame_transform_core.sv =====
// quaternion point frame transform core, top level
// Rotates each Q15.16 point by the Q1.14 quaternion as q*p*conj(q) (a non-unit
// quaternion scales by its squared norm), adds the translation and saturates to
// 32 bits. One point is accepted per cycle unless the pipeline stalls, and passes
// through five register stages: quaternion products, rotation matrix, nine
// 32x32 multipliers, row sums with rounding, then translation and clipping.
// Each stage holds its request on a stall and frees up as soon as the stage
// after it moves, so new points enter while a result waits. The user must write
// registers over the APB port only while no point is in flight (not enforced).
`include "quaternion_point_frame_transform_core_assert.svh"

module quaternion_point_frame_transform_core
  import qpft_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  qpft_in_if.sink           pt_i,
  qpft_out_if.source        res_o
);

  localparam int unsigned NStg = 5;

  // configuration registers
  quat_t    rot_q   [4];
  coord_t   shift_q [3];
  reg_idx_e reg_idx;

  assign reg_idx = reg_idx_e'(paddr[4:2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_q[0]   <= QMAG;
      rot_q[1]   <= '0;
      rot_q[2]   <= '0;
      rot_q[3]   <= '0;
      shift_q[0] <= '0;
      shift_q[1] <= '0;
      shift_q[2] <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_ROT_W:   rot_q[0]   <= pwdata[15:0];
        REG_ROT_X:   rot_q[1]   <= pwdata[15:0];
        REG_ROT_Y:   rot_q[2]   <= pwdata[15:0];
        REG_ROT_Z:   rot_q[3]   <= pwdata[15:0];
        REG_SHIFT_X: shift_q[0] <= pwdata;
        REG_SHIFT_Y: shift_q[1] <= pwdata;
        REG_SHIFT_Z: shift_q[2] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ROT_W:   prdata = 32'(rot_q[0]);
      REG_ROT_X:   prdata = 32'(rot_q[1]);
      REG_ROT_Y:   prdata = 32'(rot_q[2]);
      REG_ROT_Z:   prdata = 32'(rot_q[3]);
      REG_SHIFT_X: prdata = shift_q[0];
      REG_SHIFT_Y: prdata = shift_q[1];
      REG_SHIFT_Z: prdata = shift_q[2];
      default:     prdata = '0;
    endcase
  end

  // pipeline control
  logic [NStg:1] vld_q;
  logic [NStg:1] lst_q;
  logic [NStg:1] stg_en;
  logic [NStg:0] vld_in;

  assign vld_in = {vld_q, pt_i.valid};

  always_comb begin
    stg_en[NStg] = !vld_q[NStg] || res_o.ready;
    for (int k = NStg - 1; k >= 1; k--) begin
      stg_en[k] = !vld_q[k] || stg_en[k+1];
    end
  end

  assign pt_i.ready = stg_en[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 1; k <= NStg; k++) begin
        if (stg_en[k]) begin
          vld_q[k] <= vld_in[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (stg_en[1]) begin
      lst_q[1] <= pt_i.last_point;
    end
    for (int k = 2; k <= NStg; k++) begin
      if (stg_en[k]) begin
        lst_q[k] <= lst_q[k-1];
      end
    end
  end

  // stage 1: quaternion products
  qprod_t qe [4];
  qprod_t ww_q, xx_q, yy_q, zz_q, xy_q, xz_q, yz_q, wx_q, wy_q, wz_q;
  coord_t pt1_q [3];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      qe[k] = 30'(clamp_q(rot_q[k]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (stg_en[1]) begin
      ww_q     <= qe[0] * qe[0];
      xx_q     <= qe[1] * qe[1];
      yy_q     <= qe[2] * qe[2];
      zz_q     <= qe[3] * qe[3];
      xy_q     <= qe[1] * qe[2];
      xz_q     <= qe[1] * qe[3];
      yz_q     <= qe[2] * qe[3];
      wx_q     <= qe[0] * qe[1];
      wy_q     <= qe[0] * qe[2];
      wz_q     <= qe[0] * qe[3];
      pt1_q[0] <= pt_i.point_x;
      pt1_q[1] <= pt_i.point_y;
      pt1_q[2] <= pt_i.point_z;
    end
  end

  // stage 2: rotation matrix, Q3.28
  mat_t   m_q   [3][3];
  coord_t pt2_q [3];

  always_ff @(posedge clk_i) begin
    if (stg_en[2]) begin
      m_q[0][0] <= 32'(ww_q) + 32'(xx_q) - 32'(yy_q) - 32'(zz_q);
      m_q[0][1] <= (32'(xy_q) - 32'(wz_q)) <<< 1;
      m_q[0][2] <= (32'(xz_q) + 32'(wy_q)) <<< 1;
      m_q[1][0] <= (32'(xy_q) + 32'(wz_q)) <<< 1;
      m_q[1][1] <= 32'(ww_q) - 32'(xx_q) + 32'(yy_q) - 32'(zz_q);
      m_q[1][2] <= (32'(yz_q) - 32'(wx_q)) <<< 1;
      m_q[2][0] <= (32'(xz_q) - 32'(wy_q)) <<< 1;
      m_q[2][1] <= (32'(yz_q) + 32'(wx_q)) <<< 1;
      m_q[2][2] <= 32'(ww_q) - 32'(xx_q) - 32'(yy_q) + 32'(zz_q);
      pt2_q     <= pt1_q;
    end
  end

  // stage 3: matrix times point
  mprod_t mp_q [3][3];

  always_ff @(posedge clk_i) begin
    if (stg_en[3]) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          mp_q[i][j] <= 63'(m_q[i][j]) * 63'(pt2_q[j]);
        end
      end
    end
  end

  // stage 4: row sums plus half lsb
  acc_t acc_q [3];

  always_ff @(posedge clk_i) begin
    if (stg_en[4]) begin
      for (int i = 0; i < 3; i++) begin
        acc_q[i] <= 64'(mp_q[i][0]) + 64'(mp_q[i][1]) + 64'(mp_q[i][2]) + ROUND_HALF;
      end
    end
  end

  // stage 5: drop fraction, translate, clip
  rsum_t  rsum_d [3];
  coord_t res_d  [3];
  logic   sat_d;
  coord_t res_q  [3];
  logic   sat_q;

  always_comb begin
    sat_d = 1'b0;
    for (int i = 0; i < 3; i++) begin
      rsum_d[i] = 37'($signed(acc_q[i][63:FracShift])) + 37'(shift_q[i]);
      if (rsum_d[i] > 37'(COORD_MAX)) begin
        res_d[i] = COORD_MAX;
        sat_d    = 1'b1;
      end else if (rsum_d[i] < 37'(COORD_MIN)) begin
        res_d[i] = COORD_MIN;
        sat_d    = 1'b1;
      end else begin
        res_d[i] = rsum_d[i][31:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (stg_en[5]) begin
      res_q <= res_d;
      sat_q <= sat_d;
    end
  end

  assign res_o.valid       = vld_q[NStg];
  assign res_o.out_x       = res_q[0];
  assign res_o.out_y       = res_q[1];
  assign res_o.out_z       = res_q[2];
  assign res_o.last_result = lst_q[NStg];
  assign res_o.saturated   = sat_q;

  // checks
  `QPFT_ASSERT_IMP(a_full_blocks_req, (&vld_q) && !res_o.ready, !pt_i.ready,
    "full pipeline took a request")
  `QPFT_ASSERT_NXT(a_stalled_stage_holds, vld_q[1] && !stg_en[2], vld_q[1],
    "stalled request lost in stage 1")
  `QPFT_ASSERT_IMP(a_sat_clipped, res_o.valid && res_o.saturated,
    res_o.out_x == COORD_MAX || res_o.out_x == COORD_MIN ||
    res_o.out_y == COORD_MAX || res_o.out_y == COORD_MIN ||
    res_o.out_z == COORD_MAX || res_o.out_z == COORD_MIN,
    "saturated flag without clipped coordinate")

endmodule
